// ===== rtl/core/hsv2rgb_pkg.sv =====
// Shared types and constants of the HSV to RGB converter.
package hsv2rgb_pkg;

    // Hue circle and fixed-point scales
    localparam logic [14:0] HUE_FULL    = 15'd23040;
    localparam logic [11:0] SECTOR_SPAN = 12'd3840;
    localparam logic [7:0]  UNIT        = 8'd255;
    localparam logic [19:0] DENOM_QT    = 20'd979200;
    // DENOM_QT with the low eight zero bits taken out (255 * 15)
    localparam logic [11:0] QT_DIV      = 12'd3825;
    // Reciprocals for division by constant, floor of 2^k / divisor
    localparam int          RECIP_P_SHIFT  = 16;
    localparam logic [8:0]  RECIP_P        = 9'((1 << 16) / 255);
    localparam int          RECIP_QT_SHIFT = 28;
    localparam logic [16:0] RECIP_QT       = 17'((1 << 28) / 3825);

    typedef enum logic [2:0] {
        SECTOR_0,
        SECTOR_1,
        SECTOR_2,
        SECTOR_3,
        SECTOR_4,
        SECTOR_5
    } sector_t;

    typedef struct packed {
        logic [14:0] hue;
        logic [7:0]  saturation;
        logic [7:0]  brightness;
    } hsv_word_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_word_t;

    typedef struct packed {
        sector_t     sector;
        logic [11:0] frac;
        logic [7:0]  saturation;
        logic [7:0]  brightness;
        logic        grey;
    } cls_word_t;

endpackage

// ===== rtl/core/hsv_to_rgb_converter_top.sv =====
// Top level of the HSV to RGB converter.
//
// Usage: present an HSV word on hsv and raise start; the word is taken at
// any rising edge where start is high and busy is low. hue is in 1/64
// degree units (a value of 23040 or more wraps once), saturation and
// brightness are 8-bit fractions of 255.
// Each word yields one RGB word on rgb, marked by done for exactly one
// cycle; the receiver takes it at the edge ending that cycle and has no
// way to hold it off.
// Throughput: one word per clock. An accepted word is first held in the
// queue, then passes through the five stages of the multiply pipeline
// (products, numerators, scaling, reciprocal estimate, correction and
// channel select into the output register).
// The back end never stalls, so busy stays low in normal use; it only
// rises if the queue is full.
// Reset clears the queue and every valid flag; no word is in flight
// afterwards and done stays low until a new word has passed through.
module hsv_to_rgb_converter_top
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  hsv2rgb_pkg::hsv_word_t hsv,
    output logic                   done,
    output hsv2rgb_pkg::rgb_word_t rgb
);

    hsv2rgb_pkg::cls_word_t cls_word;
    hsv2rgb_pkg::cls_word_t head_word;
    logic                   head_valid;
    logic                   queue_full;
    logic                   push;

    // Take a word whenever start is high and the queue has room
    assign push = start && !queue_full;
    assign busy = queue_full;

    hsv2rgb_front u_front
    (
        .hsv (hsv),
        .cls (cls_word)
    );

    hsv2rgb_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_word  (cls_word),
        .head_valid (head_valid),
        .head_word  (head_word),
        .full       (queue_full)
    );

    hsv2rgb_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (head_valid),
        .in_word   (head_word),
        .out_valid (done),
        .out_word  (rgb)
    );

endmodule

// ===== rtl/core/hsv2rgb_front.sv =====
// Front end: wrap the hue, split it into sector and fraction, flag grey.
module hsv2rgb_front
(
    input  hsv2rgb_pkg::hsv_word_t hsv,
    output hsv2rgb_pkg::cls_word_t cls
);

    logic [14:0]          hue_wrapped;
    logic [14:0]          sector_base;
    hsv2rgb_pkg::sector_t sector_sel;

    // Wrap an out-of-range hue once around the circle
    always_comb
    begin
        if (hsv.hue >= hsv2rgb_pkg::HUE_FULL)
        begin
            hue_wrapped = hsv.hue - hsv2rgb_pkg::HUE_FULL;
        end
        else
        begin
            hue_wrapped = hsv.hue;
        end
    end

    // Compare against the sector boundaries
    always_comb
    begin
        if (hue_wrapped >= 15'(5 * 3840))
        begin
            sector_sel  = hsv2rgb_pkg::SECTOR_5;
            sector_base = 15'(5 * 3840);
        end
        else if (hue_wrapped >= 15'(4 * 3840))
        begin
            sector_sel  = hsv2rgb_pkg::SECTOR_4;
            sector_base = 15'(4 * 3840);
        end
        else if (hue_wrapped >= 15'(3 * 3840))
        begin
            sector_sel  = hsv2rgb_pkg::SECTOR_3;
            sector_base = 15'(3 * 3840);
        end
        else if (hue_wrapped >= 15'(2 * 3840))
        begin
            sector_sel  = hsv2rgb_pkg::SECTOR_2;
            sector_base = 15'(2 * 3840);
        end
        else if (hue_wrapped >= 15'(3840))
        begin
            sector_sel  = hsv2rgb_pkg::SECTOR_1;
            sector_base = 15'(3840);
        end
        else
        begin
            sector_sel  = hsv2rgb_pkg::SECTOR_0;
            sector_base = 15'd0;
        end
    end

    logic [14:0] frac_wide;

    assign frac_wide      = hue_wrapped - sector_base;
    assign cls.sector     = sector_sel;
    assign cls.frac       = frac_wide[11:0];
    assign cls.saturation = hsv.saturation;
    assign cls.brightness = hsv.brightness;
    assign cls.grey       = (hsv.saturation == 8'd0);

endmodule

// ===== rtl/core/hsv2rgb_queue.sv =====
// Short word queue between the front end and the arithmetic back end.
module hsv2rgb_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  hsv2rgb_pkg::cls_word_t push_word,
    output logic                   head_valid,
    output hsv2rgb_pkg::cls_word_t head_word,
    output logic                   full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    hsv2rgb_pkg::cls_word_t entry_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    // The back end never stalls: drain whenever a word is held
    assign head_valid = (count_reg != '0);
    assign pop        = head_valid;
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_word  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (count_reg != '0))
        else $error("queue empty after a push");

endmodule

// ===== rtl/core/hsv2rgb_back.sv =====
// Back end: five-stage fixed-point pipeline producing the RGB word.
module hsv2rgb_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  hsv2rgb_pkg::cls_word_t in_word,
    output logic                   out_valid,
    output hsv2rgb_pkg::rgb_word_t out_word
);

    // Stage 1: raw products
    logic                   s1_valid_reg;
    hsv2rgb_pkg::cls_word_t s1_word_reg;
    logic [15:0]            s1_mp_reg, s1_mp_next;
    logic [19:0]            s1_u_reg, s1_u_next;

    // Stage 2: numerators and first estimate of p
    logic                   s2_valid_reg;
    hsv2rgb_pkg::cls_word_t s2_word_reg;
    logic [15:0]            s2_mp_reg;
    logic [8:0]             s2_pe_reg, s2_pe_next;
    logic [19:0]            s2_nq_reg, s2_nq_next;
    logic [19:0]            s2_nt_reg, s2_nt_next;

    // Stage 3: scaled numerators, final p
    logic                   s3_valid_reg;
    hsv2rgb_pkg::cls_word_t s3_word_reg;
    logic [7:0]             s3_p_reg, s3_p_next;
    logic [27:0]            s3_xq_reg, s3_xq_next;
    logic [27:0]            s3_xt_reg, s3_xt_next;

    // Stage 4: quotient estimates of q and t
    logic                   s4_valid_reg;
    hsv2rgb_pkg::cls_word_t s4_word_reg;
    logic [7:0]             s4_p_reg;
    logic [19:0]            s4_yq_reg;
    logic [19:0]            s4_yt_reg;
    logic [8:0]             s4_eq_reg, s4_eq_next;
    logic [8:0]             s4_et_reg, s4_et_next;

    // Output register
    logic                   out_valid_reg;
    hsv2rgb_pkg::rgb_word_t out_word_reg, out_word_next;

    function automatic logic [8:0] est_qt(input logic [19:0] y);
        logic [36:0] prod;
        prod = 37'(y) * 37'(hsv2rgb_pkg::RECIP_QT);
        return prod[36:hsv2rgb_pkg::RECIP_QT_SHIFT];
    endfunction

    // Estimate is at most one short: compare remainder and bump
    function automatic logic [7:0] fix_qt(input logic [19:0] y, input logic [8:0] e);
        logic [20:0] back_prod;
        logic [20:0] rem;
        back_prod = 21'(e) * 21'(hsv2rgb_pkg::QT_DIV);
        rem       = 21'(y) - back_prod;
        if (rem[12:0] >= 13'(hsv2rgb_pkg::QT_DIV))
        begin
            return e[7:0] + 8'd1;
        end
        return e[7:0];
    endfunction

    logic [24:0] p_est_prod;
    logic [16:0] p_back_prod;
    logic [16:0] p_rem;
    logic [20:0] nt_wide;
    logic [7:0]  q_chan;
    logic [7:0]  t_chan;
    logic [7:0]  v_chan;
    logic [7:0]  p_chan;

    always_comb
    begin
        s1_mp_next = 16'(in_word.brightness) * 16'(hsv2rgb_pkg::UNIT - in_word.saturation);
        s1_u_next  = 20'(in_word.saturation) * 20'(in_word.frac);

        p_est_prod = 25'(s1_mp_reg) * 25'(hsv2rgb_pkg::RECIP_P);
        s2_pe_next = p_est_prod[24:hsv2rgb_pkg::RECIP_P_SHIFT];
        s2_nq_next = hsv2rgb_pkg::DENOM_QT - s1_u_reg;
        nt_wide    = 21'(hsv2rgb_pkg::DENOM_QT)
                   - 21'(s1_word_reg.saturation) * 21'(hsv2rgb_pkg::SECTOR_SPAN)
                   + 21'(s1_u_reg);
        s2_nt_next = nt_wide[19:0];

        p_back_prod = 17'(s2_pe_reg) * 17'(hsv2rgb_pkg::UNIT);
        p_rem       = 17'(s2_mp_reg) - p_back_prod;
        if (p_rem >= 17'(hsv2rgb_pkg::UNIT))
        begin
            s3_p_next = s2_pe_reg[7:0] + 8'd1;
        end
        else
        begin
            s3_p_next = s2_pe_reg[7:0];
        end
        s3_xq_next = 28'(s2_word_reg.brightness) * 28'(s2_nq_reg);
        s3_xt_next = 28'(s2_word_reg.brightness) * 28'(s2_nt_reg);

        s4_eq_next = est_qt(s3_xq_reg[27:8]);
        s4_et_next = est_qt(s3_xt_reg[27:8]);
    end

    // Final correction and six-sector channel select; a grey word gives brightness on all channels
    always_comb
    begin
        q_chan = fix_qt(s4_yq_reg, s4_eq_reg);
        t_chan = fix_qt(s4_yt_reg, s4_et_reg);
        v_chan = s4_word_reg.brightness;
        p_chan = s4_p_reg;
        if (s4_word_reg.grey)
        begin
            out_word_next = '{red: v_chan, green: v_chan, blue: v_chan};
        end
        else
        begin
            case (s4_word_reg.sector)
                hsv2rgb_pkg::SECTOR_0:
                    out_word_next = '{red: v_chan, green: t_chan, blue: p_chan};
                hsv2rgb_pkg::SECTOR_1:
                    out_word_next = '{red: q_chan, green: v_chan, blue: p_chan};
                hsv2rgb_pkg::SECTOR_2:
                    out_word_next = '{red: p_chan, green: v_chan, blue: t_chan};
                hsv2rgb_pkg::SECTOR_3:
                    out_word_next = '{red: p_chan, green: q_chan, blue: v_chan};
                hsv2rgb_pkg::SECTOR_4:
                    out_word_next = '{red: t_chan, green: p_chan, blue: v_chan};
                default:
                    out_word_next = '{red: v_chan, green: p_chan, blue: q_chan};
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_word_reg  <= in_word;
        s1_mp_reg    <= s1_mp_next;
        s1_u_reg     <= s1_u_next;
        s2_word_reg  <= s1_word_reg;
        s2_mp_reg    <= s1_mp_reg;
        s2_pe_reg    <= s2_pe_next;
        s2_nq_reg    <= s2_nq_next;
        s2_nt_reg    <= s2_nt_next;
        s3_word_reg  <= s2_word_reg;
        s3_p_reg     <= s3_p_next;
        s3_xq_reg    <= s3_xq_next;
        s3_xt_reg    <= s3_xt_next;
        s4_word_reg  <= s3_word_reg;
        s4_p_reg     <= s3_p_reg;
        s4_yq_reg    <= s3_xq_reg[27:8];
        s4_yt_reg    <= s3_xt_reg[27:8];
        s4_eq_reg    <= s4_eq_next;
        s4_et_reg    <= s4_et_next;
        out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (s1_word_reg.frac < hsv2rgb_pkg::SECTOR_SPAN))
        else $error("hue fraction outside its sector");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_word_reg.grey) |-> ##4
            (out_valid_reg && out_word_reg.red == out_word_reg.green
                           && out_word_reg.green == out_word_reg.blue))
        else $error("grey word did not come out grey");

endmodule

// ===== bench/hsv_to_rgb_converter_checker.sv =====
// Checker for the HSV to RGB converter: predicts each RGB word and compares.
`timescale 1ns / 100ps

module hsv_to_rgb_converter_checker
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  hsv2rgb_pkg::hsv_word_t hsv,
    input  logic                   done,
    input  hsv2rgb_pkg::rgb_word_t rgb,
    output int                     mismatch_count,
    output int                     rgb_pending
);

    hsv2rgb_pkg::rgb_word_t rgb_expected[$];

    // Exact rational form of the six-sector mapping, floored per channel.
    function automatic hsv2rgb_pkg::rgb_word_t hsv_to_rgb(hsv2rgb_pkg::hsv_word_t c);
        longint unsigned        span;
        longint unsigned        unit_scale;
        longint unsigned        denom;
        longint unsigned        h;
        longint unsigned        s;
        longint unsigned        v;
        longint unsigned        f;
        longint unsigned        p;
        longint unsigned        q;
        longint unsigned        t;
        hsv2rgb_pkg::sector_t   sec;
        hsv2rgb_pkg::rgb_word_t w;
        span       = hsv2rgb_pkg::SECTOR_SPAN;
        unit_scale = hsv2rgb_pkg::UNIT;
        denom      = hsv2rgb_pkg::DENOM_QT;
        h          = c.hue;
        s          = c.saturation;
        v          = c.brightness;
        // wrap once past the full circle
        if (h >= hsv2rgb_pkg::HUE_FULL)
            h = h - hsv2rgb_pkg::HUE_FULL;
        if (s == 0)
        begin
            w = '{red: v[7:0], green: v[7:0], blue: v[7:0]};
        end
        else
        begin
            sec = hsv2rgb_pkg::sector_t'(h / span);
            f   = h % span;
            p   = v * (unit_scale - s) / unit_scale;
            q   = v * (denom - s * f) / denom;
            t   = v * (denom - s * (span - f)) / denom;
            case (sec)
                hsv2rgb_pkg::SECTOR_0: w = '{red: v[7:0], green: t[7:0], blue: p[7:0]};
                hsv2rgb_pkg::SECTOR_1: w = '{red: q[7:0], green: v[7:0], blue: p[7:0]};
                hsv2rgb_pkg::SECTOR_2: w = '{red: p[7:0], green: v[7:0], blue: t[7:0]};
                hsv2rgb_pkg::SECTOR_3: w = '{red: p[7:0], green: q[7:0], blue: v[7:0]};
                hsv2rgb_pkg::SECTOR_4: w = '{red: t[7:0], green: p[7:0], blue: v[7:0]};
                default:               w = '{red: v[7:0], green: p[7:0], blue: q[7:0]};
            endcase
        end
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hsv2rgb_pkg::rgb_word_t want;
        if (!rst_n)
        begin
            rgb_expected.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (done)
            begin
                if (rgb_expected.size() == 0)
                begin
                    $display("%0t: unexpected rgb word r=%0d g=%0d b=%0d",
                             $time, rgb.red, rgb.green, rgb.blue);
                    mismatch_count = mismatch_count + 1;
                end
                else
                begin
                    want = rgb_expected.pop_front();
                    if (rgb.red !== want.red || rgb.green !== want.green ||
                        rgb.blue !== want.blue)
                    begin
                        $display("%0t: rgb mismatch expected r=%0d g=%0d b=%0d %s",
                                 $time, want.red, want.green, want.blue,
                                 $sformatf("actual r=%0d g=%0d b=%0d",
                                           rgb.red, rgb.green, rgb.blue));
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
            if (start && !busy)
                rgb_expected.push_back(hsv_to_rgb(hsv));
        end
        rgb_pending = rgb_expected.size();
    end

endmodule

// ===== bench/hsv_to_rgb_converter_top_test.sv =====
// Testbench top for the HSV to RGB converter: stimulus and verdict.
`timescale 1ns / 100ps

module hsv_to_rgb_converter_top_test;

    // Number of random words per idling phase; four phases give about 900.
    localparam int PHASE_WORDS = 225;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    hsv2rgb_pkg::hsv_word_t hsv;
    logic                   done;
    hsv2rgb_pkg::rgb_word_t rgb;
    int                     mismatch_count;
    int                     rgb_pending;

    // Sender idle chance, in percent, for each random phase. The receiver
    // cannot hold results off, so only the sender idles.
    int        idle_pct[4] = '{0, 64, 30, 0};

    always #5 clk = ~clk;

    hsv_to_rgb_converter_top dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .hsv   (hsv),
        .done  (done),
        .rgb   (rgb)
    );

    // The checker watches both channels beside the block and keeps the
    // store of expected RGB words; it hands back its failure count.
    hsv_to_rgb_converter_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .hsv            (hsv),
        .done           (done),
        .rgb            (rgb),
        .mismatch_count (mismatch_count),
        .rgb_pending    (rgb_pending)
    );

    // Present one word, idling first at the given chance, and hold it until
    // the block takes it. busy is read at the falling edge, well clear of
    // the rising edge where it may change. start is left high afterwards so
    // that back-to-back words need no second assignment in one step.
    task automatic send_word(hsv2rgb_pkg::hsv_word_t w, int pct);
        logic taken;
        taken = 1'b0;
        while ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        hsv   <= w;
        start <= 1'b1;
        while (!taken)
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
    endtask

    // Drop start and wait until every expected word has come back.
    task automatic drain;
        start <= 1'b0;
        do
            @(negedge clk);
        while (rgb_pending != 0);
        @(posedge clk);
    endtask

    // Random colour, weighted towards sector edges, the wrap range and
    // the extremes of saturation and brightness.
    function automatic hsv2rgb_pkg::hsv_word_t random_colour();
        hsv2rgb_pkg::hsv_word_t c;
        int unsigned            pick;
        pick = $urandom_range(9);
        if (pick <= 5)
            c.hue = 15'($urandom_range(23039));
        else if (pick == 6)
            c.hue = 15'($urandom_range(32767, 23040));
        else if (pick == 7)
            c.hue = 15'($urandom_range(32767));
        else
            c.hue = 15'($urandom_range(5) * hsv2rgb_pkg::SECTOR_SPAN +
                        (($urandom_range(1) == 1) ? $urandom_range(3839, 3836)
                                                  : $urandom_range(3)));
        pick = $urandom_range(9);
        c.saturation = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(255));
        pick = $urandom_range(9);
        c.brightness = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(255));
        return c;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        hsv   = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: every sector start, the hue ends, wrap past the
        // full circle, grey at zero saturation, and the field extremes.
        send_word('{hue: 15'd0,     saturation: 8'd255, brightness: 8'd255}, 0);
        send_word('{hue: 15'd1,     saturation: 8'd255, brightness: 8'd255}, 0);
        send_word('{hue: 15'd3839,  saturation: 8'd255, brightness: 8'd255}, 0);
        send_word('{hue: 15'd3840,  saturation: 8'd255, brightness: 8'd255}, 0);
        send_word('{hue: 15'd7680,  saturation: 8'd255, brightness: 8'd255}, 0);
        send_word('{hue: 15'd11520, saturation: 8'd255, brightness: 8'd255}, 0);
        send_word('{hue: 15'd15360, saturation: 8'd255, brightness: 8'd255}, 0);
        send_word('{hue: 15'd19200, saturation: 8'd255, brightness: 8'd255}, 0);
        send_word('{hue: 15'd23039, saturation: 8'd255, brightness: 8'd255}, 0);
        send_word('{hue: 15'd23040, saturation: 8'd255, brightness: 8'd255}, 0);
        send_word('{hue: 15'd32767, saturation: 8'd255, brightness: 8'd255}, 0);
        send_word('{hue: 15'd1920,  saturation: 8'd128, brightness: 8'd200}, 0);
        send_word('{hue: 15'd5760,  saturation: 8'd77,  brightness: 8'd180}, 0);
        send_word('{hue: 15'd9600,  saturation: 8'd200, brightness: 8'd90},  0);
        send_word('{hue: 15'd13440, saturation: 8'd1,   brightness: 8'd255}, 0);
        send_word('{hue: 15'd17280, saturation: 8'd254, brightness: 8'd128}, 0);
        send_word('{hue: 15'd21120, saturation: 8'd100, brightness: 8'd33},  0);
        send_word('{hue: 15'd5000,  saturation: 8'd0,   brightness: 8'd173}, 0);
        send_word('{hue: 15'd32767, saturation: 8'd0,   brightness: 8'd255}, 0);
        send_word('{hue: 15'd0,     saturation: 8'd0,   brightness: 8'd0},   0);
        send_word('{hue: 15'd12000, saturation: 8'd255, brightness: 8'd0},   0);
        send_word('{hue: 15'd20000, saturation: 8'd1,   brightness: 8'd1},   0);

        // Hold off until the pipeline is empty before the random part.
        drain();

        // Random phases, each followed by a full drain so that the block
        // starts every phase from idle.
        foreach (idle_pct[ph])
        begin
            repeat (PHASE_WORDS)
                send_word(random_colour(), idle_pct[ph]);
            drain();
        end

        // Allow a margin for any stray word to come out of the pipeline.
        repeat (10) @(posedge clk);

        if (mismatch_count == 0)
            $display("hsv_to_rgb_converter_top_test: PASS");
        else
            $display("hsv_to_rgb_converter_top_test: FAIL");
        $finish;
    end

    // Guard against a hang: far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("hsv_to_rgb_converter_top_test: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/hsv2rgb_pkg.sv
rtl/core/hsv2rgb_front.sv
rtl/core/hsv2rgb_queue.sv
rtl/core/hsv2rgb_back.sv
rtl/core/hsv_to_rgb_converter_top.sv
bench/hsv_to_rgb_converter_checker.sv
bench/hsv_to_rgb_converter_top_test.sv
